// File: sv/arfp_pkg.sv
// arfp_pkg: types, character codes, frame offsets and status codes of the
// ascii range frame parser; used by every module of the block but arfp_fifo
`default_nettype none
package arfp_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MID_DEPTH_DEF   = 2;
    localparam int OUT_DEPTH_DEF   = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;
    localparam logic [1:0] ST_AMP  = 2'd3;

    localparam logic [6:0] TY_DIST   = 7'd21;
    localparam logic [6:0] TY_CONT_A = 7'd24;
    localparam logic [6:0] TY_CONT_B = 7'd25;
    localparam logic [6:0] TY_LASER  = 7'd26;
    localparam logic [6:0] TY_ACK    = 7'd33;

    localparam logic [7:0] POS_COUNT_PAIR = 8'd4;
    localparam logic [7:0] POS_TYPE_PAIR  = 8'd6;
    localparam logic [7:0] POS_FIELD_LO   = 8'd7;
    localparam logic [7:0] POS_COUNT_END  = 8'd10;
    localparam logic [7:0] POS_SHORT_END  = 8'd14;
    localparam logic [7:0] POS_DIST_END   = 8'd18;
    localparam logic [7:0] POS_MAX_END    = 8'd26;
    localparam logic [7:0] POS_MIN_END    = 8'd34;

    typedef enum logic [1:0] {
        TOK_START,
        TOK_AMP,
        TOK_BYTE
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] pos;
        logic       dig;
        logic [3:0] digit;
        logic [6:0] pv;
        logic       add_sum;
        logic       set_type;
        logic       oversize;
        logic       finish;
        logic [7:0] fend;
    } t_tok;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [6:0]  msg_type;
        logic        unknown_type;
        logic [13:0] sample_count;
        logic [26:0] distance_mm;
        logic [26:0] max_distance_mm;
        logic [26:0] min_distance_mm;
        logic        laser_on;
        logic        response_seen;
    } t_res;

endpackage
`default_nettype wire

// File: sv/arfp_fifo.sv
// arfp_fifo: small register queue with push/full and pop/empty sides
// no package dependency; DEPTH must be at least 2
`default_nettype none
module arfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/arfp_front.sv
// arfp_front: byte framing; hunts for the start mark, tracks offset, pair
// digits and pair count, and emits one token per relevant item; uses arfp_pkg
`default_nettype none
module arfp_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_rx_byte,
    output logic              o_tok_push,
    output arfp_pkg::t_tok    o_tok
);
    import arfp_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_pos, n_pos;
    logic [6:0] r_pcnt, n_pcnt;
    logic [3:0] r_first, n_first;
    logic       r_first_bad, n_first_bad;

    logic       dig;
    logic [3:0] digit;
    logic [7:0] p;
    logic [6:0] pv;
    logic [6:0] pc_eff;
    logic [7:0] fend;
    logic       is_pair;
    logic       oversize;
    logic       in_count;
    logic [9:0] need_bytes;

    assign dig        = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit      = dig ? i_rx_byte[3:0] : 4'd0;
    assign p          = r_pos + 8'd1;
    assign pv         = (r_first_bad || !dig) ? 7'd0
                        : ({r_first, 3'b000} + {2'b00, r_first, 1'b0} + {3'b000, digit});
    assign pc_eff     = (p == POS_COUNT_PAIR) ? pv : r_pcnt;
    assign fend       = {pc_eff, 1'b0} + POS_COUNT_PAIR;
    assign is_pair    = (p >= POS_COUNT_PAIR) && !p[0];
    assign need_bytes = {2'b00, pv, 1'b0} + 10'd6;
    assign oversize   = (p == POS_COUNT_PAIR) && (need_bytes > 10'(MAX_FRAME_BYTES));
    assign in_count   = ({1'b0, p[7:1]} < ({1'b0, r_pcnt} + 8'd2));

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_pcnt      = r_pcnt;
        n_first     = r_first;
        n_first_bad = r_first_bad;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == CH_DOLLAR) begin
                    n_in_frame  = 1'b1;
                    n_pos       = '0;
                    n_pcnt      = '0;
                    n_first     = '0;
                    n_first_bad = 1'b0;
                end
            end else begin
                n_pos = p;
                if (p >= 8'd3 && p[0]) begin
                    n_first     = digit;
                    n_first_bad = !dig;
                end
                if (p == POS_COUNT_PAIR) begin
                    n_pcnt = pv;
                end
                if (oversize || (p == fend)) begin
                    n_in_frame = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_tok          = '0;
        o_tok.pos      = p;
        o_tok.dig      = dig;
        o_tok.digit    = digit;
        o_tok.pv       = pv;
        o_tok.add_sum  = is_pair && ((p == POS_COUNT_PAIR) || in_count);
        o_tok.set_type = (p == POS_TYPE_PAIR);
        o_tok.oversize = oversize;
        o_tok.finish   = (p == fend) && !oversize;
        o_tok.fend     = fend;
        o_tok_push     = 1'b0;
        if (r_in_frame) begin
            o_tok.kind = TOK_BYTE;
            o_tok_push = i_accept;
        end else if (i_rx_byte == CH_DOLLAR) begin
            o_tok.kind = TOK_START;
            o_tok_push = i_accept;
        end else begin
            o_tok.kind = TOK_AMP;
            o_tok_push = i_accept && (i_rx_byte == CH_AMP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_pos       <= '0;
            r_pcnt      <= '0;
            r_first     <= '0;
            r_first_bad <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_pos       <= n_pos;
            r_pcnt      <= n_pcnt;
            r_first     <= n_first;
            r_first_bad <= n_first_bad;
        end
    end

endmodule
`default_nettype wire

// File: sv/arfp_back.sv
// arfp_back: consumes tokens; field accumulators, checksum, stored status
// and result building; uses arfp_pkg
`default_nettype none
module arfp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tok_valid,
    input  wire arfp_pkg::t_tok i_tok,
    output logic               o_tok_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output arfp_pkg::t_res     o_res
);
    import arfp_pkg::*;

    function automatic logic [26:0] dec_shift(input logic [26:0] a, input logic [3:0] d);
        dec_shift = {a[23:0], 3'b000} + {a[25:0], 1'b0} + {23'd0, d};
    endfunction

    function automatic logic [26:0] field_val(input logic [26:0] a, input logic bad,
                                               input logic [7:0] last, input logic [7:0] fend);
        field_val = (bad || (last > fend)) ? 27'd0 : a;
    endfunction

    logic [6:0]  r_sum, n_sum;
    logic [6:0]  r_type, n_type;
    logic [13:0] r_cnt_acc, n_cnt_acc;
    logic [26:0] r_dist_acc, n_dist_acc;
    logic [26:0] r_max_acc, n_max_acc;
    logic [26:0] r_min_acc, n_min_acc;
    logic [3:0]  r_bad, n_bad;
    logic [13:0] r_count, n_count;
    logic [26:0] r_dist, n_dist;
    logic [26:0] r_max, n_max;
    logic [26:0] r_min, n_min;
    logic        r_laser, n_laser;
    logic        r_ack, n_ack;

    logic        go;
    logic [7:0]  sum_raw;
    logic        cont_type;
    logic [1:0]  res_status;
    logic [6:0]  res_type;
    logic        res_unk;

    assign go        = i_tok_valid && !i_res_full;
    assign o_tok_pop = go;
    assign sum_raw   = {1'b0, r_sum} + {1'b0, i_tok.pv};
    assign cont_type = (r_type == TY_CONT_A) || (r_type == TY_CONT_B);

    always_comb begin
        n_sum      = r_sum;
        n_type     = r_type;
        n_cnt_acc  = r_cnt_acc;
        n_dist_acc = r_dist_acc;
        n_max_acc  = r_max_acc;
        n_min_acc  = r_min_acc;
        n_bad      = r_bad;
        n_count    = r_count;
        n_dist     = r_dist;
        n_max      = r_max;
        n_min      = r_min;
        n_laser    = r_laser;
        n_ack      = r_ack;
        o_res_push = 1'b0;
        res_status = ST_OK;
        res_type   = '0;
        res_unk    = 1'b0;
        if (go) begin
            unique case (i_tok.kind)
                TOK_START: begin
                    n_sum      = '0;
                    n_type     = '0;
                    n_cnt_acc  = '0;
                    n_dist_acc = '0;
                    n_max_acc  = '0;
                    n_min_acc  = '0;
                    n_bad      = '0;
                end
                TOK_AMP: begin
                    o_res_push = 1'b1;
                    res_status = ST_AMP;
                end
                TOK_BYTE: begin
                    // field digits, offsets 7 to 34
                    if (i_tok.pos >= POS_FIELD_LO && i_tok.pos <= POS_MIN_END) begin
                        if (cont_type) begin
                            priority if (i_tok.pos <= POS_COUNT_END) begin
                                if (i_tok.dig) begin
                                    n_cnt_acc = 14'(dec_shift(27'(r_cnt_acc), i_tok.digit));
                                end else begin
                                    n_bad[0] = 1'b1;
                                end
                            end else if (i_tok.pos <= POS_DIST_END) begin
                                if (i_tok.dig) begin
                                    n_dist_acc = dec_shift(r_dist_acc, i_tok.digit);
                                end else begin
                                    n_bad[1] = 1'b1;
                                end
                            end else if (i_tok.pos <= POS_MAX_END) begin
                                if (i_tok.dig) begin
                                    n_max_acc = dec_shift(r_max_acc, i_tok.digit);
                                end else begin
                                    n_bad[2] = 1'b1;
                                end
                            end else begin
                                if (i_tok.dig) begin
                                    n_min_acc = dec_shift(r_min_acc, i_tok.digit);
                                end else begin
                                    n_bad[3] = 1'b1;
                                end
                            end
                        end else if (r_type == TY_DIST && i_tok.pos <= POS_SHORT_END) begin
                            if (i_tok.dig) begin
                                n_dist_acc = dec_shift(r_dist_acc, i_tok.digit);
                            end else begin
                                n_bad[1] = 1'b1;
                            end
                        end
                    end
                    if (i_tok.add_sum) begin
                        n_sum = (sum_raw >= 8'd100) ? 7'(sum_raw - 8'd100) : sum_raw[6:0];
                    end
                    if (i_tok.set_type) begin
                        n_type = i_tok.pv;
                    end
                    if (i_tok.oversize) begin
                        o_res_push = 1'b1;
                        res_status = ST_LONG;
                    end else if (i_tok.finish) begin
                        o_res_push = 1'b1;
                        res_type   = n_type;
                        if (n_sum != i_tok.pv) begin
                            res_status = ST_CSUM;
                        end else begin
                            res_status = ST_OK;
                            priority if (n_type == TY_ACK) begin
                                n_ack = 1'b1;
                            end else if (n_type == TY_CONT_A || n_type == TY_CONT_B) begin
                                n_count = 14'(field_val(27'(n_cnt_acc), n_bad[0],
                                                        POS_COUNT_END, i_tok.fend));
                                n_dist  = field_val(n_dist_acc, n_bad[1], POS_DIST_END,
                                                    i_tok.fend);
                                n_max   = field_val(n_max_acc, n_bad[2], POS_MAX_END,
                                                    i_tok.fend);
                                n_min   = field_val(n_min_acc, n_bad[3], POS_MIN_END,
                                                    i_tok.fend);
                            end else if (n_type == TY_DIST) begin
                                n_dist = field_val(n_dist_acc, n_bad[1], POS_SHORT_END,
                                                   i_tok.fend);
                            end else if (n_type == TY_LASER) begin
                                n_laser = !r_laser;
                            end else begin
                                res_unk = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res.frame_status    = res_status;
        o_res.msg_type        = res_type;
        o_res.unknown_type    = res_unk;
        o_res.sample_count    = n_count;
        o_res.distance_mm     = n_dist;
        o_res.max_distance_mm = n_max;
        o_res.min_distance_mm = n_min;
        o_res.laser_on        = n_laser;
        o_res.response_seen   = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_type     <= '0;
            r_cnt_acc  <= '0;
            r_dist_acc <= '0;
            r_max_acc  <= '0;
            r_min_acc  <= '0;
            r_bad      <= '0;
            r_count    <= '0;
            r_dist     <= '0;
            r_max      <= '0;
            r_min      <= '0;
            r_laser    <= 1'b0;
            r_ack      <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_type     <= n_type;
            r_cnt_acc  <= n_cnt_acc;
            r_dist_acc <= n_dist_acc;
            r_max_acc  <= n_max_acc;
            r_min_acc  <= n_min_acc;
            r_bad      <= n_bad;
            r_count    <= n_count;
            r_dist     <= n_dist;
            r_max      <= n_max;
            r_min      <= n_min;
            r_laser    <= n_laser;
            r_ack      <= n_ack;
        end
    end

endmodule
`default_nettype wire

// File: sv/ascii_range_frame_parser.sv
// ascii_range_frame_parser: top level; framing front, token queue, frame
// back end and result queue; uses arfp_pkg, arfp_fifo, arfp_front, arfp_back
//
// usage:
//   input side is a queue: drive i_rx_byte with push; a byte is taken at an
//   edge with push high and full low. one received byte per item.
//   result side is a queue: while empty is low the oldest result sits on the
//   o_ ports; it is taken at an edge with pop high and empty low.
//   a result comes for each finished frame (accepted, checksum mismatch or
//   oversized) and for an ampersand seen while hunting; other bytes give none.
//   the token of the byte ending a frame passes the token queue, then the
//   back end pushes its result into the result queue. throughput, unless
//   stalled: one byte per cycle; the back end handles one token a cycle.
//   stall: with pop low the result queue fills, the back end holds its token,
//   the token queue fills and full rises; nothing is dropped.
//   reset (synchronous, i_rst_n low): both queues empty, parser hunting for
//   the start mark, all stored status cleared to zero.
`default_nettype none
module ascii_range_frame_parser #(
    parameter int MID_DEPTH = arfp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = arfp_pkg::OUT_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_frame_status,
    output logic [6:0]       o_msg_type,
    output logic             o_unknown_type,
    output logic [13:0]      o_sample_count,
    output logic [26:0]      o_distance_mm,
    output logic [26:0]      o_max_distance_mm,
    output logic [26:0]      o_min_distance_mm,
    output logic             o_laser_on,
    output logic             o_response_seen
);
    import arfp_pkg::*;

    localparam int TOK_W = $bits(t_tok);
    localparam int RES_W = $bits(t_res);

    logic accept;
    logic tok_push;
    t_tok tok_in, tok_out;
    logic tok_empty;
    logic tok_pop;
    logic res_push;
    logic res_full;
    t_res res_in, res_out;

    assign accept = push && !full;

    arfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_tok_push (tok_push),
        .o_tok      (tok_in)
    );

    arfp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (MID_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_empty (tok_empty),
        .o_data  (tok_out)
    );

    arfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (tok_out),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    arfp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_frame_status    = res_out.frame_status;
    assign o_msg_type        = res_out.msg_type;
    assign o_unknown_type    = res_out.unknown_type;
    assign o_sample_count    = res_out.sample_count;
    assign o_distance_mm     = res_out.distance_mm;
    assign o_max_distance_mm = res_out.max_distance_mm;
    assign o_min_distance_mm = res_out.min_distance_mm;
    assign o_laser_on        = res_out.laser_on;
    assign o_response_seen   = res_out.response_seen;

    // a result is only built from a token taken in the same cycle
    a_res_needs_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (tok_pop && !res_full))
        else $error("result pushed without a consumed token");

    // an unknown type is only flagged on an accepted frame
    a_unk_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_in.unknown_type) |-> (res_in.frame_status == ST_OK))
        else $error("unknown type on a rejected frame");

    // oversized and ampersand results carry type zero
    a_reject_type_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && (res_in.frame_status == ST_LONG || res_in.frame_status == ST_AMP))
        |-> (res_in.msg_type == '0))
        else $error("nonzero type on early reject");

    // the laser state only changes on an accepted laser frame
    a_laser_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && (res_in.laser_on != $past(res_in.laser_on)) && $past(res_push)
         && $past(i_rst_n))
        |-> (res_in.frame_status == ST_OK && res_in.msg_type == TY_LASER))
        else $error("laser state changed outside a laser frame");

endmodule
`default_nettype wire

// File: tb/sv/arfp_frame_scoreboard_pkg.sv
`timescale 1ns / 100ps
// frame scoreboard for the ascii range frame parser: predicts the results of the
// received bytes and checks them in order; depends on arfp_pkg
package arfp_frame_scoreboard_pkg;
    import arfp_pkg::*;

    localparam int BAD_TYPE  = 0;
    localparam int BAD_COUNT = 1;
    localparam int BAD_DIST  = 2;
    localparam int BAD_MAX   = 3;
    localparam int BAD_MIN   = 4;

    localparam int CSUM_MOD = 100;

    class arfp_frame_scoreboard;
        t_res        pending_results[$];
        int          errors;
        int          status_seen[4];

        bit          framing;
        logic [7:0]  pos;
        logic [6:0]  n_pairs;
        logic [3:0]  hi_digit;
        logic        hi_bad;
        logic [12:0] csum_acc;
        logic [6:0]  ty_acc;
        logic [13:0] cnt_acc;
        logic [26:0] dist_acc;
        logic [26:0] dmax_acc;
        logic [26:0] dmin_acc;
        logic [4:0]  bad_mask;

        logic [13:0] cnt_st;
        logic [26:0] dist_st;
        logic [26:0] dmax_st;
        logic [26:0] dmin_st;
        logic        laser_st;
        logic        ack_st;

        function new();
            open_frame();
            framing  = 1'b0;
            cnt_st   = '0;
            dist_st  = '0;
            dmax_st  = '0;
            dmin_st  = '0;
            laser_st = 1'b0;
            ack_st   = 1'b0;
        endfunction

        function void open_frame();
            framing  = 1'b1;
            pos      = '0;
            n_pairs  = '0;
            hi_digit = '0;
            hi_bad   = 1'b0;
            csum_acc = '0;
            ty_acc   = '0;
            cnt_acc  = '0;
            dist_acc = '0;
            dmax_acc = '0;
            dmin_acc = '0;
            bad_mask = '0;
        endfunction

        function void add_expected(logic [1:0] st, logic [6:0] ty, logic unk);
            t_res r;
            r.frame_status    = st;
            r.msg_type        = ty;
            r.unknown_type    = unk;
            r.sample_count    = cnt_st;
            r.distance_mm     = dist_st;
            r.max_distance_mm = dmax_st;
            r.min_distance_mm = dmin_st;
            r.laser_on        = laser_st;
            r.response_seen   = ack_st;
            pending_results.push_back(r);
            status_seen[st]++;
        endfunction

        function logic [26:0] field_or_zero(logic [26:0] acc, int bad_bit,
                                            logic [7:0] last, int fend);
            if (bad_mask[bad_bit] || int'(last) > fend)
                return '0;
            return acc;
        endfunction

        function void close_frame(logic [6:0] csum, int fend);
            logic unk;
            unk     = 1'b0;
            framing = 1'b0;
            if (csum_acc != 13'(csum)) begin
                add_expected(ST_CSUM, ty_acc, 1'b0);
                return;
            end
            if (ty_acc == TY_ACK) begin
                ack_st = 1'b1;
            end else if (ty_acc == TY_CONT_A || ty_acc == TY_CONT_B) begin
                cnt_st  = 14'(field_or_zero(27'(cnt_acc), BAD_COUNT, POS_COUNT_END, fend));
                dist_st = field_or_zero(dist_acc, BAD_DIST, POS_DIST_END, fend);
                dmax_st = field_or_zero(dmax_acc, BAD_MAX, POS_MAX_END, fend);
                dmin_st = field_or_zero(dmin_acc, BAD_MIN, POS_MIN_END, fend);
            end else if (ty_acc == TY_DIST) begin
                dist_st = field_or_zero(dist_acc, BAD_DIST, POS_SHORT_END, fend);
            end else if (ty_acc == TY_LASER) begin
                laser_st = ~laser_st;
            end else begin
                unk = 1'b1;
            end
            add_expected(ST_OK, ty_acc, unk);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            logic       dig;
            logic [3:0] d;
            logic [7:0] p;
            logic [6:0] pv;
            int         idx;
            int         fend;
            dig = (b >= CH_ZERO && b <= CH_NINE);
            d   = dig ? 4'(b - CH_ZERO) : 4'd0;
            if (!framing) begin
                if (b == CH_DOLLAR)
                    open_frame();
                else if (b == CH_AMP)
                    add_expected(ST_AMP, 7'd0, 1'b0);
                return;
            end
            p   = pos + 8'd1;
            pos = p;
            if (p >= POS_FIELD_LO && p <= POS_MIN_END) begin
                if (ty_acc == TY_CONT_A || ty_acc == TY_CONT_B) begin
                    if (p <= POS_COUNT_END) begin
                        if (dig) cnt_acc = 14'(cnt_acc * 10 + d);
                        else bad_mask[BAD_COUNT] = 1'b1;
                    end else if (p <= POS_DIST_END) begin
                        if (dig) dist_acc = 27'(dist_acc * 10 + d);
                        else bad_mask[BAD_DIST] = 1'b1;
                    end else if (p <= POS_MAX_END) begin
                        if (dig) dmax_acc = 27'(dmax_acc * 10 + d);
                        else bad_mask[BAD_MAX] = 1'b1;
                    end else begin
                        if (dig) dmin_acc = 27'(dmin_acc * 10 + d);
                        else bad_mask[BAD_MIN] = 1'b1;
                    end
                end else if (ty_acc == TY_DIST && p <= POS_SHORT_END) begin
                    if (dig) dist_acc = 27'(dist_acc * 10 + d);
                    else bad_mask[BAD_DIST] = 1'b1;
                end
            end
            // offsets 1 and 2 carry nothing
            if (p < POS_COUNT_PAIR - 8'd1)
                return;
            if (p[0]) begin
                hi_digit = d;
                hi_bad   = ~dig;
                return;
            end
            pv  = (hi_bad || !dig) ? 7'd0 : 7'(hi_digit * 10 + d);
            idx = (int'(p) - 3) >> 1;
            if (p == POS_COUNT_PAIR) begin
                n_pairs  = pv;
                csum_acc = 13'((csum_acc + pv) % CSUM_MOD);
                if (2 * int'(n_pairs) + 6 > MAX_FRAME_BYTES) begin
                    framing = 1'b0;
                    add_expected(ST_LONG, 7'd0, 1'b0);
                    return;
                end
            end else if (idx < int'(n_pairs)) begin
                csum_acc = 13'((csum_acc + pv) % CSUM_MOD);
            end
            if (p == POS_TYPE_PAIR) begin
                ty_acc = pv;
                if (pv == 7'd0)
                    bad_mask[BAD_TYPE] = 1'b1;
            end
            fend = 2 * int'(n_pairs) + 4;
            if (int'(p) == fend)
                close_frame(pv, fend);
        endfunction

        function void check_frame_result(t_res got);
            t_res        want;
            logic [26:0] w[9];
            logic [26:0] g[9];
            string       names[9];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, got status %0d type %0d",
                         $time, got.frame_status, got.msg_type);
                return;
            end
            want  = pending_results.pop_front();
            names = '{"frame_status", "msg_type", "unknown_type", "sample_count",
                      "distance_mm", "max_distance_mm", "min_distance_mm",
                      "laser_on", "response_seen"};
            w = '{27'(want.frame_status), 27'(want.msg_type), 27'(want.unknown_type),
                  27'(want.sample_count), want.distance_mm, want.max_distance_mm,
                  want.min_distance_mm, 27'(want.laser_on), 27'(want.response_seen)};
            g = '{27'(got.frame_status), 27'(got.msg_type), 27'(got.unknown_type),
                  27'(got.sample_count), got.distance_mm, got.max_distance_mm,
                  got.min_distance_mm, 27'(got.laser_on), 27'(got.response_seen)};
            for (int i = 0; i < 9; i++) begin
                if (w[i] !== g[i]) begin
                    errors++;
                    $display("%0t mismatch %s: expected %0d, got %0d",
                             $time, names[i], w[i], g[i]);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/sv/ascii_range_frame_parser_test.sv
`timescale 1ns / 100ps
// testbench top for ascii_range_frame_parser: directed and random frames with
// random idling on both sides; depends on arfp_pkg and arfp_frame_scoreboard_pkg
module ascii_range_frame_parser_test;
    import arfp_pkg::*;
    import arfp_frame_scoreboard_pkg::*;

    localparam int CLK_PERIOD         = 10;
    localparam int WATCHDOG_LIMIT     = 4000;
    localparam int RESULT_HOLD_CYCLES = 400;
    localparam int FRAME_BYTE_TARGET  = 950;
    localparam int RESULT_TARGET      = 60;
    localparam int PHASE_FRAMES       = 8;
    localparam int TAIL_CYCLES        = 20;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        pop       = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_frame_status;
    logic [6:0]  o_msg_type;
    logic        o_unknown_type;
    logic [13:0] o_sample_count;
    logic [26:0] o_distance_mm;
    logic [26:0] o_max_distance_mm;
    logic [26:0] o_min_distance_mm;
    logic        o_laser_on;
    logic        o_response_seen;

    arfp_frame_scoreboard sb;
    t_res                 popped;
    int                   quiet_cycles    = 0;
    int                   sender_idle_pct = 0;
    int                   pop_stall_pct   = 0;
    bit                   result_hold_req = 1'b0;
    int                   bytes_sent      = 0;
    int                   ignored_bytes   = 0;
    int                   frames_sent     = 0;

    ascii_range_frame_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (i_rx_byte),
        .empty             (empty),
        .pop               (pop),
        .o_frame_status    (o_frame_status),
        .o_msg_type        (o_msg_type),
        .o_unknown_type    (o_unknown_type),
        .o_sample_count    (o_sample_count),
        .o_distance_mm     (o_distance_mm),
        .o_max_distance_mm (o_max_distance_mm),
        .o_min_distance_mm (o_min_distance_mm),
        .o_laser_on        (o_laser_on),
        .o_response_seen   (o_response_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_rx_byte(i_rx_byte);
            if (pop && !empty) begin
                popped = {o_frame_status, o_msg_type, o_unknown_type, o_sample_count,
                          o_distance_mm, o_max_distance_mm, o_min_distance_mm,
                          o_laser_on, o_response_seen};
                sb.check_frame_result(popped);
            end
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("[ascii_range_frame_parser] ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (result_hold_req) begin
                pop <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge i_clk);
                result_hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // returns at the accepting edge with push still high
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do
            @(posedge i_clk);
        while (full);
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] ascii_digit(input int v);
        return CH_ZERO + 8'(v);
    endfunction

    function automatic logic [7:0] rand_data(input int bad_pct);
        if ($urandom_range(99) < bad_pct)
            return 8'($urandom_range(255));
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic int pair_value(input logic [7:0] hi, input logic [7:0] lo);
        if (hi >= CH_ZERO && hi <= CH_NINE && lo >= CH_ZERO && lo <= CH_NINE)
            return int'(hi - CH_ZERO) * 10 + int'(lo - CH_ZERO);
        return 0;
    endfunction

    // ty below zero leaves the type pair random
    task automatic send_frame(input int n, input int ty, input int bad_pct,
                              input bit good_csum);
        logic [7:0] fb[$];
        int         sum;
        int         csum;
        fb.push_back(CH_DOLLAR);
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(ascii_digit(n / 10));
        fb.push_back(ascii_digit(n % 10));
        if (2 * n + 6 <= MAX_FRAME_BYTES) begin
            for (int k = 5; k <= 2 * n + 2; k++) begin
                if (ty >= 0 && k == 5)
                    fb.push_back(ascii_digit(ty / 10));
                else if (ty >= 0 && k == 6)
                    fb.push_back(ascii_digit(ty % 10));
                else
                    fb.push_back(rand_data(ty >= 0 ? bad_pct : 50));
            end
            if (n > 0) begin
                sum = 0;
                for (int i = 0; i < n; i++)
                    sum += pair_value(fb[3 + 2 * i], fb[4 + 2 * i]);
                csum = good_csum ? sum % 100 : (sum + $urandom_range(1, 99)) % 100;
                fb.push_back(ascii_digit(csum / 10));
                if (good_csum || $urandom_range(3) != 0)
                    fb.push_back(ascii_digit(csum % 10));
                else
                    fb.push_back(rand_data(100));
            end
        end
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    initial begin : stimulus
        int r;
        bit good;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stray ampersand, ignored byte, zero pair count, largest count
        send_text("&");
        send_text("Z");
        send_text("$ab00");
        send_text("$ab99");
        // dollar and ampersand inside a frame, laser toggle
        send_text("$$&022628");
        // byte extremes inside an acknowledge frame
        send_byte(CH_DOLLAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("023335");
        drain_results();

        // long result stall while bytes keep coming
        result_hold_req = 1'b1;
        repeat (10) send_text("$ab00");
        drain_results();

        while (bytes_sent - ignored_bytes < FRAME_BYTE_TARGET ||
               sb.status_seen.sum() < RESULT_TARGET) begin
            if (frames_sent % PHASE_FRAMES == 0) begin
                drain_results();
                case ((frames_sent / PHASE_FRAMES) % 4)
                    0: begin sender_idle_pct = 0;  pop_stall_pct = 0;  end
                    1: begin sender_idle_pct = 86; pop_stall_pct = 0;  end
                    2: begin sender_idle_pct = 0;  pop_stall_pct = 86; end
                    default: begin sender_idle_pct = 30; pop_stall_pct = 30; end
                endcase
            end
            r    = $urandom_range(99);
            good = ($urandom_range(9) != 0);
            if (r < 30) begin
                send_frame($urandom_range(4) == 0 ? $urandom_range(17, 29) : 16,
                           $urandom_range(1) ? TY_CONT_A : TY_CONT_B, 3, good);
            end else if (r < 45) begin
                send_frame($urandom_range(2) == 0 ? $urandom_range(7, 20) : 6,
                           TY_DIST, 3, good);
            end else if (r < 55) begin
                send_frame($urandom_range(2, 4), $urandom_range(1) ? TY_LASER : TY_ACK,
                           0, good);
            end else if (r < 63) begin
                send_frame($urandom_range(0, 29), $urandom_range(99), 10, good);
            end else if (r < 70) begin
                // measurement fields that the frame end may cut short
                send_frame($urandom_range(2, 15),
                           $urandom_range(2) == 0 ? TY_DIST :
                           ($urandom_range(1) ? TY_CONT_A : TY_CONT_B), 5, good);
            end else if (r < 74) begin
                send_frame($urandom_range(30, 99), $urandom_range(99), 0, 1'b1);
            end else if (r < 78) begin
                send_frame($urandom_range(0, 29), -1, 30, good);
            end else if (r < 86) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(255)));
                    ignored_bytes++;
                end
            end else if (r < 92) begin
                send_byte(CH_AMP);
            end else begin
                send_byte(CH_DOLLAR);
                repeat ($urandom_range(1, 8)) send_byte(rand_data(40));
            end
            frames_sent++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes (%0d hunting noise) over %0d random frames after directed cases",
                 bytes_sent, ignored_bytes, frames_sent);
        $display("results: %0d accepted, %0d checksum mismatch, %0d oversized, %0d stray ampersand",
                 sb.status_seen[ST_OK], sb.status_seen[ST_CSUM],
                 sb.status_seen[ST_LONG], sb.status_seen[ST_AMP]);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[ascii_range_frame_parser] OK");
        else
            $display("[ascii_range_frame_parser] ERROR");
        $finish;
    end

endmodule
